[rtl/core/fwl_pkg.sv]
package fwl_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = 4;
    localparam int TIME_W  = 64;
    localparam int SEC_W   = 32;
    localparam int CNT_W   = 17;
    localparam int REG_W   = 2;

    typedef logic [1:0]        t_kind;
    typedef logic [1:0]        t_status;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [TIME_W-1:0] t_time;
    typedef logic [SEC_W-1:0]  t_sec;
    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [REG_W-1:0]  t_reg;

    localparam t_kind KIND_CHECK = 2'd0;
    localparam t_kind KIND_FAIL  = 2'd1;
    localparam t_kind KIND_CLEAR = 2'd2;

    localparam t_status ST_ALLOWED = 2'd0;
    localparam t_status ST_BLOCKED = 2'd1;
    localparam t_status ST_ERROR   = 2'd2;

    localparam t_reg REG_WINDOW = 2'd0;
    localparam t_reg REG_LIMIT  = 2'd1;
    localparam t_reg REG_BLOCK  = 2'd2;

    localparam t_count COUNT_CAP = 17'd99999;

    localparam t_sec   WINDOW_RST = 32'd300;
    localparam t_count LIMIT_RST  = 17'd5;
    localparam t_sec   BLOCK_RST  = 32'd900;

endpackage

[rtl/core/fwl_in_if.sv]
interface fwl_in_if import fwl_pkg::*;;
    logic  valid;
    logic  ready;
    t_kind kind;
    t_idx  entry_index;
    t_time now;

    modport source (output valid, output kind, output entry_index, output now, input ready);
    modport sink   (input valid, input kind, input entry_index, input now, output ready);
endinterface

[rtl/core/fwl_out_if.sv]
interface fwl_out_if import fwl_pkg::*;;
    logic    valid;
    logic    ready;
    t_status status;

    modport source (output valid, output status, input ready);
    modport sink   (input valid, input status, output ready);
endinterface

[rtl/core/fwl_cfg_if.sv]
interface fwl_cfg_if import fwl_pkg::*;;
    logic valid;
    logic ready;
    t_reg index;
    t_sec data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/failure_window_lockout.sv]
// Pipeline: input register, then result register; a stalled result also holds the input register.
// Throughput: one request per cycle unless output stalls; the tracker table is read and written
// in the cycle the result register loads, so back-to-back requests on one entry see fresh state.
// Reset (synchronous, active low): all trackers read as zero, window 300, limit 5,
// block 900, both pipeline stages empty. Configuration writes are always taken.
module failure_window_lockout import fwl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fwl_cfg_if.sink   i_cfg,
    fwl_in_if.sink    i_req,
    fwl_out_if.source o_rsp
);

    t_sec   r_win;
    t_count r_limit;
    t_sec   r_block;

    logic   r_in_vld;
    t_kind  r_kind;
    t_idx   r_idx;
    t_time  r_now;

    logic    r_out_vld;
    t_status r_status;

    logic [ENTRIES-1:0] r_ent_vld;
    t_time  r_start [ENTRIES];
    t_count r_count [ENTRIES];
    t_time  r_until [ENTRIES];

    logic    w_adv;
    logic    w_in_range;
    t_time   w_cur_start;
    t_count  w_cur_count;
    t_time   w_cur_until;
    t_time   w_diff;
    logic [TIME_W:0] w_sum;
    logic    w_new_win;
    t_count  w_cnt;

    t_status n_status;
    logic    n_wr;
    logic    n_clr;
    t_time   n_start;
    t_count  n_count;
    t_time   n_until;

    assign w_adv       = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_in_vld || w_adv;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid  = r_out_vld;
    assign o_rsp.status = r_status;

    assign w_in_range  = int'(r_idx) < ENTRIES;
    assign w_cur_start = r_ent_vld[r_idx] ? r_start[r_idx] : '0;
    assign w_cur_count = r_ent_vld[r_idx] ? r_count[r_idx] : '0;
    assign w_cur_until = r_ent_vld[r_idx] ? r_until[r_idx] : '0;

    assign w_diff    = r_now - w_cur_start;
    assign w_sum     = {1'b0, r_now} + {{(TIME_W+1-SEC_W){1'b0}}, r_block};
    assign w_new_win = (w_cur_start == '0) ||
                       (w_diff >= {{(TIME_W-SEC_W){1'b0}}, r_win});
    assign w_cnt     = w_new_win ? t_count'(1) : w_cur_count + t_count'(1);

    always_comb begin
        n_status = ST_ERROR;
        n_wr     = 1'b0;
        n_clr    = 1'b0;
        n_start  = w_new_win ? r_now : w_cur_start;
        n_count  = w_cnt;
        n_until  = w_new_win ? '0 : w_cur_until;
        if (w_in_range) begin
            case (r_kind)
                KIND_CHECK: begin
                    if (w_cur_start > r_now) begin
                        n_status = ST_ERROR;
                    end else if (w_cur_until > r_now) begin
                        n_status = ST_BLOCKED;
                    end else begin
                        n_status = ST_ALLOWED;
                    end
                end
                KIND_FAIL: begin
                    if (w_cur_start > r_now) begin
                        n_status = ST_ERROR;
                    end else if (w_cur_until > r_now) begin
                        n_status = ST_BLOCKED;
                    end else if (!w_new_win && (w_cur_count >= COUNT_CAP)) begin
                        n_status = ST_ERROR;
                    end else if (w_cnt >= r_limit) begin
                        if (w_sum[TIME_W]) begin
                            n_status = ST_ERROR;
                        end else begin
                            n_status = ST_BLOCKED;
                            n_until  = w_sum[TIME_W-1:0];
                            n_wr     = 1'b1;
                        end
                    end else begin
                        n_status = ST_ALLOWED;
                        n_wr     = 1'b1;
                    end
                end
                KIND_CLEAR: begin
                    n_status = ST_ALLOWED;
                    n_clr    = 1'b1;
                end
                default: begin
                    n_status = ST_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= WINDOW_RST;
            r_limit <= LIMIT_RST;
            r_block <= BLOCK_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_WINDOW: r_win   <= i_cfg.data;
                REG_LIMIT:  r_limit <= i_cfg.data[CNT_W-1:0];
                REG_BLOCK:  r_block <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_kind <= i_req.kind;
            r_idx  <= i_req.entry_index;
            r_now  <= i_req.now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
        end else if (w_adv && n_wr) begin
            r_ent_vld[r_idx] <= 1'b1;
        end else if (w_adv && n_clr) begin
            r_ent_vld[r_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && n_wr) begin
            r_start[r_idx] <= n_start;
            r_count[r_idx] <= n_count;
            r_until[r_idx] <= n_until;
        end
    end

endmodule

[rtl/core/fwl_chk.sv]
module fwl_chk import fwl_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_status i_status
);

    // only the three defined codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_ALLOWED || i_status == ST_BLOCKED ||
                         i_status == ST_ERROR))
        else $error("fwl: undefined status code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status))
        else $error("fwl: stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && i_in_ready)
        else $error("fwl: pipeline not empty after reset");

    // a request taken with the result side empty is followed by a valid result, after the input register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_out_valid |=> ##1 i_out_valid)
        else $error("fwl: result missing after request");

endmodule

bind failure_window_lockout fwl_chk u_fwl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status)
);

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
    import fwl_pkg::*;

    localparam t_kind KIND_UNUSED = 2'd3;
    localparam t_time T_MAX       = '1;
    localparam int    QUIET_LIMIT = 4000;
    localparam int    HOLD_CYCLES = 400;

    typedef struct packed {
        t_kind kind;
        t_idx  idx;
        t_time now;
    } t_lock_req;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fwl_cfg_if cfg_if ();
    fwl_in_if  req_if ();
    fwl_out_if rsp_if ();

    failure_window_lockout dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // tracker table and registers as the block should hold them
    t_time  win_beg  [ENTRIES];
    t_count fail_cnt [ENTRIES];
    t_time  blk_end  [ENTRIES];
    t_sec   cfg_window = WINDOW_RST;
    t_count cfg_limit  = LIMIT_RST;
    t_sec   cfg_block  = BLOCK_RST;

    t_lock_req pending_q[$];
    t_status   status_q[$];
    int        n_queued  = 0;
    int        n_checked = 0;
    int        fails     = 0;
    int        send_idle = 0;
    int        recv_idle = 0;
    int        hold_asks = 0;
    int        hold_seen;
    int        hold_left;
    int        quiet     = 0;
    t_lock_req cur;
    t_status   exp_st;

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            win_beg[i]  = '0;
            fail_cnt[i] = '0;
            blk_end[i]  = '0;
        end
    end

    function automatic t_status lockout_status(t_kind k, t_idx ix, t_time tn);
        t_time       wb;
        t_count      cnt;
        t_time       be;
        logic [64:0] sum;
        t_status     st;
        wb  = win_beg[ix];
        cnt = fail_cnt[ix];
        be  = blk_end[ix];
        case (k)
            KIND_CHECK: begin
                if (wb > tn) return ST_ERROR;
                return (be > tn) ? ST_BLOCKED : ST_ALLOWED;
            end
            KIND_FAIL: begin
                if (wb > tn) return ST_ERROR;
                if (be > tn) return ST_BLOCKED;
                if (wb == '0 || (tn - wb) >= t_time'(cfg_window)) begin
                    wb  = tn;
                    cnt = 17'd1;
                    be  = '0;
                end else begin
                    if (cnt >= COUNT_CAP) return ST_ERROR;
                    cnt = cnt + 17'd1;
                end
                if (cnt >= cfg_limit) begin
                    sum = {1'b0, tn} + {33'd0, cfg_block};
                    if (sum[64]) return ST_ERROR;
                    be = sum[63:0];
                    st = ST_BLOCKED;
                end else begin
                    st = ST_ALLOWED;
                end
                win_beg[ix]  = wb;
                fail_cnt[ix] = cnt;
                blk_end[ix]  = be;
                return st;
            end
            KIND_CLEAR: begin
                win_beg[ix]  = '0;
                fail_cnt[ix] = '0;
                blk_end[ix]  = '0;
                return ST_ALLOWED;
            end
            default: return ST_ERROR;
        endcase
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready)
                status_q.push_back(lockout_status(req_if.kind, req_if.entry_index, req_if.now));
            if (!req_if.valid || req_if.ready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    cur = pending_q.pop_front();
                    req_if.valid       <= 1'b1;
                    req_if.kind        <= cur.kind;
                    req_if.entry_index <= cur.idx;
                    req_if.now         <= cur.now;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // response ready, with a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= 0;
            hold_seen    <= 0;
        end else if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (hold_seen != hold_asks) begin
            rsp_if.ready <= 1'b0;
            hold_seen    <= hold_asks;
            hold_left    <= HOLD_CYCLES;
        end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (status_q.size() == 0) begin
                $error("unexpected response: status %0d", rsp_if.status);
                fails++;
            end else begin
                exp_st = status_q.pop_front();
                if (rsp_if.status !== exp_st) begin
                    $error("status mismatch: expected %0d, actual %0d", exp_st, rsp_if.status);
                    fails++;
                end
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
    end

    initial begin
        while (quiet < QUIET_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    task automatic push_req(t_kind k, t_idx ix, t_time tn);
        pending_q.push_back('{kind: k, idx: ix, now: tn});
        n_queued++;
    endtask

    task automatic push_random(int n, int unsigned step_max, int sh, t_time base);
        t_time       t;
        t_time       tn;
        t_kind       k;
        t_idx        ix;
        int unsigned r;
        t = base;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 60)      k = KIND_FAIL;
            else if (r < 90) k = KIND_CHECK;
            else if (r < 97) k = KIND_CLEAR;
            else             k = KIND_UNUSED;
            ix = ($urandom_range(9) < 7) ? t_idx'($urandom_range(3)) : t_idx'($urandom_range(15));
            r = $urandom_range(99);
            if (r < 3) begin
                tn = {$urandom, $urandom};
            end else if (r < 5) begin
                tn = T_MAX - t_time'($urandom_range(step_max));
            end else if (r < 10) begin
                tn = t - (t_time'($urandom_range(step_max)) << sh);
            end else begin
                t  = t + (t_time'($urandom_range(step_max)) << sh);
                tn = t;
            end
            push_req(k, ix, tn);
        end
    endtask

    task automatic write_reg(t_reg r, t_sec d);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= r;
        cfg_if.data  <= d;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (r)
            REG_WINDOW: cfg_window = d;
            REG_LIMIT:  cfg_limit  = d[CNT_W-1:0];
            REG_BLOCK:  cfg_block  = d;
            default: ;
        endcase
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_drain();
        do @(posedge i_clk); while (n_checked != n_queued);
    endtask

    initial begin
        i_rst_n            = 1'b0;
        req_if.valid       = 1'b0;
        req_if.kind        = KIND_CHECK;
        req_if.entry_index = '0;
        req_if.now         = '0;
        rsp_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_WINDOW;
        cfg_if.data        = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: window 300, limit 5, block 900
        send_idle = 30;
        recv_idle = 48;
        push_req(KIND_CHECK, 4'd0, 64'd0);
        push_req(KIND_FAIL, 4'd0, 64'd0);
        push_req(KIND_FAIL, 4'd0, 64'd0);
        for (int i = 0; i < 5; i++) push_req(KIND_FAIL, 4'd1, 64'd1000 + i);
        push_req(KIND_CHECK, 4'd1, 64'd1500);
        push_req(KIND_FAIL, 4'd1, 64'd1500);
        push_req(KIND_CHECK, 4'd1, 64'd500);
        push_req(KIND_FAIL, 4'd1, 64'd999);
        push_req(KIND_CHECK, 4'd1, 64'd1904);
        push_req(KIND_FAIL, 4'd1, 64'd1904);
        push_req(KIND_FAIL, 4'd2, 64'd100);
        push_req(KIND_FAIL, 4'd2, 64'd399);
        push_req(KIND_FAIL, 4'd2, 64'd400);
        push_req(KIND_CLEAR, 4'd1, T_MAX);
        push_req(KIND_CHECK, 4'd1, 64'd0);
        push_req(KIND_UNUSED, 4'd15, T_MAX);
        push_req(KIND_FAIL, 4'd15, T_MAX);
        push_req(KIND_CHECK, 4'd15, T_MAX);
        push_random(550, 15, 0, 64'd2000);
        wait_drain();

        // window of 1, block on first failure, zero block time
        write_reg(REG_WINDOW, 32'd1);
        write_reg(REG_LIMIT, 32'd1);
        write_reg(REG_BLOCK, 32'd0);
        send_idle = 48;
        recv_idle = 30;
        hold_asks++;
        push_req(KIND_CLEAR, 4'd4, 64'd0);
        push_req(KIND_FAIL, 4'd4, 64'd10);
        push_req(KIND_CHECK, 4'd4, 64'd10);
        push_req(KIND_FAIL, 4'd4, 64'd10);
        push_req(KIND_FAIL, 4'd4, 64'd11);
        push_random(250, 2, 0, 64'h1_0000_0000);
        wait_drain();

        write_reg(REG_WINDOW, t_sec'($urandom_range(60, 10)));
        write_reg(REG_LIMIT, t_sec'($urandom_range(6, 2)));
        write_reg(REG_BLOCK, t_sec'($urandom_range(100)));
        push_random(300, 5, 0, 64'd5000);
        wait_drain();

        // widest window, limit 0, longest block: overflow near the top of time
        write_reg(REG_WINDOW, '1);
        write_reg(REG_LIMIT, 32'd0);
        write_reg(REG_BLOCK, '1);
        write_reg(t_reg'(3), 32'hA5A5_5A5A);
        send_idle = 0;
        recv_idle = 0;
        push_req(KIND_CLEAR, 4'd5, 64'd0);
        push_req(KIND_FAIL, 4'd5, T_MAX - 64'd5);
        push_req(KIND_CHECK, 4'd5, T_MAX - 64'd5);
        push_req(KIND_FAIL, 4'd5, T_MAX - 64'hFFFF_FFFF);
        push_req(KIND_CHECK, 4'd5, T_MAX);
        push_req(KIND_CLEAR, 4'd6, 64'd0);
        push_req(KIND_FAIL, 4'd6, 64'd0);
        push_req(KIND_CHECK, 4'd6, 64'd1);
        push_random(300, 32'h4000_0000, 2, 64'hFFFF_FFFE_0000_0000);
        wait_drain();

        // limit above the cap: failures keep counting and never block
        write_reg(REG_LIMIT, '1);
        push_req(KIND_CLEAR, 4'd3, 64'd0);
        for (int i = 0; i < 12; i++) push_req(KIND_FAIL, 4'd3, 64'd1);
        push_req(KIND_CHECK, 4'd3, 64'd2);
        push_req(KIND_FAIL, 4'd3, 64'd2);
        push_random(300, 50, 0, 64'd10);
        wait_drain();

        repeat (4) @(posedge i_clk);
        if (status_q.size() != 0) begin
            $error("%0d responses never arrived", status_q.size());
            fails++;
        end
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
